/* sv/ura_pkg.sv */
// ----------------------------------------------------------------------------
// ura_pkg - shared types and constants of the ultrasonic range averager
// Request payloads, divider status and the fixed-point ranging constants.
// ----------------------------------------------------------------------------
package ura_pkg;

  localparam int TICKS_W  = 16;   // echo time field
  localparam int TEMP_W   = 8;    // temperature field
  localparam int DIST_W   = 16;   // distance field
  localparam int BOUND_W  = 12;   // alarm window bounds
  localparam int ZONE_W   = 2;
  localparam int SUM_W    = 20;   // running window sum
  localparam int SPEED_W  = 21;   // speed of sound, m/s scaled by 4096
  localparam int PROD_W   = SPEED_W + TICKS_W;

  // serial divider: dividend and divisor widths
  localparam int DIV_W    = 21;
  localparam int DSR_W    = 7;

  localparam int CFG_IDX_W = 3;

  // speed_q12 = 1357414 + 249 * t
  localparam int SPEED_BASE_Q12  = 1357414;
  localparam int SPEED_SLOPE_Q12 = 249;

  // distance = ticks * speed / 8192000 = ((ticks * speed) >> 16) / 125
  localparam int DIST_SHIFT   = 16;
  localparam int DIST_DIV_ODD = 125;

  localparam logic [DIST_W-1:0] RANGE_LIMIT_MM = 16'd4000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_HIGH  = 3'd3;

  localparam logic [BOUND_W-1:0] NEAR_LOW_RST  = 12'd0;
  localparam logic [BOUND_W-1:0] NEAR_HIGH_RST = 12'd300;
  localparam logic [BOUND_W-1:0] FAR_LOW_RST   = 12'd300;
  localparam logic [BOUND_W-1:0] FAR_HIGH_RST  = 12'd800;

  // alarm zones
  localparam logic [ZONE_W-1:0] ZONE_NONE = 2'd0;
  localparam logic [ZONE_W-1:0] ZONE_NEAR = 2'd1;
  localparam logic [ZONE_W-1:0] ZONE_FAR  = 2'd2;

  typedef struct packed {
    logic [TICKS_W-1:0]       echo_ticks;
    logic signed [TEMP_W-1:0] temperature_c;
    logic                     echo_timeout;
  } ura_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance_mm;
    logic              out_of_range;
    logic [ZONE_W-1:0] alarm_zone;
  } ura_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ura_div_stat_t;

endpackage

/* sv/ultrasonic_range_averager_top.sv */
// ----------------------------------------------------------------------------
// ultrasonic_range_averager_top - ping to averaged distance and alarm zone
// Temperature-corrected time-of-flight ranging with a moving-average window.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per ping (echo ticks, temperature, timeout flag).
//   out_* : one request per ping (distance, out-of-range flag, alarm zone).
//   cfg_* : alarm window bounds, index 0..3; other indexes are ignored.
//           cfg_ready is always high; write only while the block is idle.
// Cost: a 16-step serial multiplier (one echo-tick bit a cycle) and a
//   21-step serial divider (one quotient bit a cycle), used once for the /125
//   of the distance scaling and, for every ping from the AVG_DEPTH-th on,
//   once more for the window mean; the first AVG_DEPTH-1 pings skip it.
// Throughput: one ping at a time; in_ready is high only while idle, so a new
//   ping is taken only after the last one has left the send step.
// The result register frees the core: a new ping is taken while a result
//   still waits, and the core only holds if it finishes before the receiver
//   takes that earlier result.
// Reset: window empty, pointer and sum cleared, bounds back to 0/300/300/800.
//   Ring contents are not cleared; entries are read only once all written.
// ----------------------------------------------------------------------------
module ultrasonic_range_averager_top #(
  parameter int AVG_DEPTH = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  ura_pkg::ura_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ura_pkg::ura_out_t                out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ura_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ura_pkg::BOUND_W-1:0]      cfg_data
);

  localparam int PTR_W  = $clog2(AVG_DEPTH);
  localparam int FILL_W = $clog2(AVG_DEPTH + 1);
  localparam int MCNT_W = $clog2(ura_pkg::TICKS_W);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV_RAW, S_UPDATE, S_DIV_MEAN, S_SEND
  } state_t;

  state_t state;

  // window bounds
  logic [ura_pkg::BOUND_W-1:0] near_low, near_high, far_low, far_high;

  // per-ping working registers
  logic [ura_pkg::PROD_W-1:0]  prod;     // shift-add product, multiplier bits at the bottom
  logic [ura_pkg::SPEED_W-1:0] speed;
  logic                        timeout;
  logic [MCNT_W-1:0]           mcnt;
  logic [ura_pkg::DIST_W-1:0]  raw;
  logic [ura_pkg::DIST_W-1:0]  dist_mm;

  // averaging window
  logic [ura_pkg::DIST_W-1:0]  ring [AVG_DEPTH];
  logic [PTR_W-1:0]            ptr;
  logic [FILL_W-1:0]           fill;
  logic [ura_pkg::SUM_W-1:0]   wsum;

  // divider
  logic                        div_start;
  logic [ura_pkg::DIV_W-1:0]   div_dividend;
  logic [ura_pkg::DSR_W-1:0]   div_divisor;
  logic [ura_pkg::DIV_W-1:0]   div_q;
  ura_pkg::ura_div_stat_t      div_stat;

  // combinational helpers
  logic signed [16:0]          slope_term;
  logic [ura_pkg::SPEED_W:0]   speed_wide;
  logic [ura_pkg::SPEED_W:0]   mul_sum;
  logic                        full;
  logic [FILL_W-1:0]           fill_next;
  logic [PTR_W-1:0]            ptr_next;
  logic [ura_pkg::DIST_W-1:0]  old_entry;
  logic [ura_pkg::SUM_W-1:0]   wsum_next;
  logic                        oor;
  logic [ura_pkg::ZONE_W-1:0]  zone;
  logic                        out_free;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // speed_q12 = base + slope * t, signed slope term, always positive result
  assign slope_term = 17'(in_data.temperature_c) * 17'(ura_pkg::SPEED_SLOPE_Q12);
  assign speed_wide = 22'(ura_pkg::SPEED_BASE_Q12) + 22'(slope_term);

  // one multiplier bit a cycle: add speed into the top half, shift right
  assign mul_sum = {1'b0, prod[ura_pkg::PROD_W-1:ura_pkg::TICKS_W]}
                 + (prod[0] ? {1'b0, speed} : '0);

  // ring bookkeeping
  assign full      = (fill == FILL_W'(AVG_DEPTH));
  assign fill_next = full ? fill : fill + 1'b1;
  assign ptr_next  = (ptr == PTR_W'(AVG_DEPTH - 1)) ? '0 : ptr + 1'b1;
  assign old_entry = full ? ring[ptr] : '0;
  assign wsum_next = wsum - ura_pkg::SUM_W'(old_entry) + ura_pkg::SUM_W'(raw);

  // divider operand select: distance scaling first, then the window mean
  assign div_dividend = (state == S_DIV_RAW) ?
                        prod[ura_pkg::PROD_W-1:ura_pkg::DIST_SHIFT] :
                        ura_pkg::DIV_W'(wsum);
  assign div_divisor  = (state == S_DIV_RAW) ?
                        ura_pkg::DSR_W'(ura_pkg::DIST_DIV_ODD) :
                        ura_pkg::DSR_W'(AVG_DEPTH);

  ura_serdiv u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // classification; zone one is tested first
  assign oor = timeout || (dist_mm >= ura_pkg::RANGE_LIMIT_MM);
  always_comb begin
    if (oor) begin
      zone = ura_pkg::ZONE_NONE;
    end else if (dist_mm > 16'(near_low) && dist_mm < 16'(near_high)) begin
      zone = ura_pkg::ZONE_NEAR;
    end else if (dist_mm > 16'(far_low) && dist_mm < 16'(far_high)) begin
      zone = ura_pkg::ZONE_FAR;
    end else begin
      zone = ura_pkg::ZONE_NONE;
    end
  end

  assign out_free = !out_valid || out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      near_low  <= ura_pkg::NEAR_LOW_RST;
      near_high <= ura_pkg::NEAR_HIGH_RST;
      far_low   <= ura_pkg::FAR_LOW_RST;
      far_high  <= ura_pkg::FAR_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ura_pkg::CFG_NEAR_LOW:  near_low  <= cfg_data;
        ura_pkg::CFG_NEAR_HIGH: near_high <= cfg_data;
        ura_pkg::CFG_FAR_LOW:   far_low   <= cfg_data;
        ura_pkg::CFG_FAR_HIGH:  far_high  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ring storage, no reset
  always_ff @(posedge clk) begin
    if (state == S_UPDATE) begin
      ring[ptr] <= raw;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
      out_valid <= 1'b0;
      ptr       <= '0;
      fill      <= '0;
      wsum      <= '0;
    end else begin
      // start pulse: end of the multiply, or the window just filled
      div_start <= (state == S_MUL && mcnt == MCNT_W'(ura_pkg::TICKS_W - 1)) ||
                   (state == S_UPDATE && fill_next == FILL_W'(AVG_DEPTH));
      // result held until taken, reloaded from the send step
      out_valid <= (state == S_SEND && out_free) || (out_valid && !out_ready);
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            prod    <= {{ura_pkg::SPEED_W{1'b0}}, in_data.echo_ticks};
            speed   <= speed_wide[ura_pkg::SPEED_W-1:0];
            timeout <= in_data.echo_timeout;
            mcnt    <= '0;
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= {mul_sum, prod[ura_pkg::TICKS_W-1:1]};
          mcnt <= mcnt + 1'b1;
          if (mcnt == MCNT_W'(ura_pkg::TICKS_W - 1)) begin
            state <= S_DIV_RAW;
          end
        end
        S_DIV_RAW: begin
          // quotient peaks near 11112, so the 16-bit slice never saturates
          if (div_stat.done) begin
            raw   <= div_q[ura_pkg::DIST_W-1:0];
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          wsum <= wsum_next;
          ptr  <= ptr_next;
          fill <= fill_next;
          if (fill_next == FILL_W'(AVG_DEPTH)) begin
            state <= S_DIV_MEAN;
          end else begin
            dist_mm <= raw;
            state   <= S_SEND;
          end
        end
        S_DIV_MEAN: begin
          if (div_stat.done) begin
            dist_mm <= div_q[ura_pkg::DIST_W-1:0];
            state   <= S_SEND;
          end
        end
        S_SEND: begin
          if (out_free) begin
            out_data.distance_mm  <= dist_mm;
            out_data.out_of_range <= oor;
            out_data.alarm_zone   <= zone;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(AVG_DEPTH) && ptr <= PTR_W'(AVG_DEPTH - 1))
    else $error("window fill or pointer out of range");

  a_out_from_send: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_SEND))
    else $error("result presented outside the send step");

  a_div_running: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_RAW || state == S_DIV_MEAN) && !div_start
      |-> div_stat.busy || div_stat.done)
    else $error("waiting on an idle divider");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_MUL && !in_ready)
    else $error("accepted ping did not start the multiplier");
`endif

endmodule

/* sv/ura_serdiv.sv */
// ----------------------------------------------------------------------------
// ura_serdiv - bit-serial restoring divider
// One quotient bit per cycle; the divisor is sampled with the start pulse.
// ----------------------------------------------------------------------------
module ura_serdiv (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ura_pkg::DIV_W-1:0]    dividend,
  input  logic [ura_pkg::DSR_W-1:0]    divisor,
  output logic [ura_pkg::DIV_W-1:0]    quotient,
  output ura_pkg::ura_div_stat_t       stat
);

  localparam int CNT_W = $clog2(ura_pkg::DIV_W);

  logic [ura_pkg::DIV_W-1:0] quo;
  logic [ura_pkg::DSR_W-1:0] rem;
  logic [ura_pkg::DSR_W-1:0] dsr;
  logic [CNT_W-1:0]          cnt;
  logic                      busy;
  logic                      done;

  logic [ura_pkg::DSR_W:0]   trial;
  logic                      ge;
  logic [ura_pkg::DSR_W-1:0] rem_next;

  // shift the next dividend bit into the partial remainder
  assign trial    = {rem, quo[ura_pkg::DIV_W-1]};
  assign ge       = trial >= {1'b0, dsr};
  assign rem_next = ge ? ura_pkg::DSR_W'(trial - {1'b0, dsr}) : trial[ura_pkg::DSR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // pulse once the last quotient bit has been shifted in
      done <= !start && busy && (cnt == CNT_W'(ura_pkg::DIV_W - 1));
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        dsr  <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[ura_pkg::DIV_W-2:0], ge};
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ura_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

`ifndef NO_ASSERTIONS
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && !done)
    else $error("divider not busy after start");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without a running division");
`endif

endmodule

/* test/tb_ultrasonic_range_averager_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ultrasonic_range_averager_top - self-checking bench for the range averager
// Drives pings through the request handshake, predicts distance, range flag
// and alarm zone with an in-bench model of the window, and checks every result
// in order across several alarm bound settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_ultrasonic_range_averager_top;

  localparam int AVG_DEPTH       = 10;
  localparam longint MM_DIVISOR  = 2000 * 4096;  // mm scaling with the q12 speed
  localparam int SETTLE_CYCLES   = 100;          // longer than the full-window latency
  localparam int PHASES          = 9;
  localparam int PINGS_PER_PHASE = 137;
  localparam int DIRECTED_ROWS   = 25;

  // Directed stimulus row: the expected result is only filled in where
  // chk is set; other rows go through the predictor.
  typedef struct packed {
    logic [ura_pkg::TICKS_W-1:0]       ticks;
    logic signed [ura_pkg::TEMP_W-1:0] temp;
    logic                              timeout;
    logic                              chk;
    logic [ura_pkg::DIST_W-1:0]        dist_mm;
    logic                              oor;
    logic [ura_pkg::ZONE_W-1:0]        zone;
  } ping_row_t;

  localparam ping_row_t DIRECTED [DIRECTED_ROWS] = '{
    // zero echo: nothing in any window under reset bounds (lower bound exclusive)
    '{16'd0,     8'sd0,    1'b0, 1'b1, 16'd0, 1'b0, ura_pkg::ZONE_NONE},
    // timed-out ping at the coldest code: flagged, distance still reported
    '{16'd0,    -8'sd128,  1'b1, 1'b1, 16'd0, 1'b1, ura_pkg::ZONE_NONE},
    '{16'd0,     8'sd127,  1'b0, 1'b1, 16'd0, 1'b0, ura_pkg::ZONE_NONE},
    // longest echo at both temperature extremes
    '{16'hFFFF,  8'sd127,  1'b0, 1'b0, 16'd0, 1'b0, ura_pkg::ZONE_NONE},
    '{16'hFFFF, -8'sd128,  1'b1, 1'b0, 16'd0, 1'b0, ura_pkg::ZONE_NONE},
    // near zone, near zone just under the near/far boundary, far zone
    '{16'd873,   8'sd20,   1'b0, 1'b0, 16'd0, 1'b0, ura_pkg::ZONE_NONE},
    '{16'd1747,  8'sd20,   1'b0, 1'b0, 16'd0, 1'b0, ura_pkg::ZONE_NONE},
    '{16'd3000,  8'sd25,   1'b0, 1'b0, 16'd0, 1'b0, ura_pkg::ZONE_NONE},
    // two long echoes just short of the 4000 mm range limit
    '{16'd23290, 8'sd20,   1'b0, 1'b0, 16'd0, 1'b0, ura_pkg::ZONE_NONE},
    '{16'd23300, 8'sd20,   1'b0, 1'b0, 16'd0, 1'b0, ura_pkg::ZONE_NONE},
    // window now full: means from here on
    '{16'd5000, -8'sd55,   1'b1, 1'b0, 16'd0, 1'b0, ura_pkg::ZONE_NONE},
    '{16'd1,     8'sd125,  1'b0, 1'b0, 16'd0, 1'b0, ura_pkg::ZONE_NONE},
    '{16'hAAAA, -8'sd86,   1'b0, 1'b0, 16'd0, 1'b0, ura_pkg::ZONE_NONE},
    '{16'h5555,  8'sd85,   1'b1, 1'b0, 16'd0, 1'b0, ura_pkg::ZONE_NONE},
    // steady short echoes flush the long ones out of the window
    '{16'd873,   8'sd0,    1'b0, 1'b0, 16'd0, 1'b0, ura_pkg::ZONE_NONE},
    '{16'd880,   8'sd20,   1'b0, 1'b0, 16'd0, 1'b0, ura_pkg::ZONE_NONE},
    '{16'd860,   8'sd40,   1'b0, 1'b0, 16'd0, 1'b0, ura_pkg::ZONE_NONE},
    '{16'd900,  -8'sd20,   1'b0, 1'b0, 16'd0, 1'b0, ura_pkg::ZONE_NONE},
    '{16'd850,   8'sd60,   1'b0, 1'b0, 16'd0, 1'b0, ura_pkg::ZONE_NONE},
    '{16'd910,  -8'sd40,   1'b0, 1'b0, 16'd0, 1'b0, ura_pkg::ZONE_NONE},
    '{16'd840,   8'sd80,   1'b0, 1'b0, 16'd0, 1'b0, ura_pkg::ZONE_NONE},
    '{16'd830,   8'sd100,  1'b0, 1'b0, 16'd0, 1'b0, ura_pkg::ZONE_NONE},
    '{16'd920,  -8'sd55,   1'b0, 1'b0, 16'd0, 1'b0, ura_pkg::ZONE_NONE},
    '{16'd820,   8'sd125,  1'b0, 1'b0, 16'd0, 1'b0, ura_pkg::ZONE_NONE},
    '{16'h8000, -8'sd1,    1'b0, 1'b0, 16'd0, 1'b0, ura_pkg::ZONE_NONE}
  };

  logic                          clk;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  ura_pkg::ura_in_t              in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  ura_pkg::ura_out_t             out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [ura_pkg::CFG_IDX_W-1:0] cfg_index = ura_pkg::CFG_NEAR_LOW;
  logic [ura_pkg::BOUND_W-1:0]   cfg_data  = '0;

  // bench copy of the block state
  logic [ura_pkg::DIST_W-1:0]  ring_mm [AVG_DEPTH];
  int                          ring_slot;
  int                          stored_count;
  logic [ura_pkg::SUM_W-1:0]   window_total;
  logic [ura_pkg::BOUND_W-1:0] near_lo, near_hi, far_lo, far_hi;

  ura_pkg::ura_out_t pending_results [$];
  ura_pkg::ura_out_t due_result;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int pings_sent     = 0;
  int results_checked = 0;
  int bound_settings = 1;
  int oor_seen       = 0;
  int near_seen      = 0;
  int far_seen       = 0;

  ultrasonic_range_averager_top #(.AVG_DEPTH(AVG_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

  // Advances the window state by one ping and returns what the block
  // should report for it.
  function automatic ura_pkg::ura_out_t predict_range(input ura_pkg::ura_in_t req);
    longint                     speed_q12;
    longint                     span_mm;
    logic [ura_pkg::DIST_W-1:0] raw_mm;
    logic [ura_pkg::DIST_W-1:0] shown_mm;
    ura_pkg::ura_out_t          res;
    speed_q12 = longint'(ura_pkg::SPEED_BASE_Q12)
              + longint'(ura_pkg::SPEED_SLOPE_Q12) * longint'(req.temperature_c);
    span_mm   = (longint'(req.echo_ticks) * speed_q12) / MM_DIVISOR;
    raw_mm    = (span_mm > 65535) ? '1 : span_mm[ura_pkg::DIST_W-1:0];
    // full ring: drop the oldest before it is overwritten
    if (stored_count == AVG_DEPTH) begin
      window_total = window_total - ura_pkg::SUM_W'(ring_mm[ring_slot]);
    end
    ring_mm[ring_slot] = raw_mm;
    window_total = window_total + ura_pkg::SUM_W'(raw_mm);
    ring_slot = (ring_slot + 1) % AVG_DEPTH;
    if (stored_count < AVG_DEPTH) stored_count++;
    shown_mm = (stored_count < AVG_DEPTH) ? raw_mm :
               ura_pkg::DIST_W'(window_total / ura_pkg::SUM_W'(AVG_DEPTH));
    res.distance_mm  = shown_mm;
    res.out_of_range = req.echo_timeout || (shown_mm >= ura_pkg::RANGE_LIMIT_MM);
    // near window wins where the two overlap; inverted windows never match
    if (res.out_of_range) res.alarm_zone = ura_pkg::ZONE_NONE;
    else if (shown_mm > near_lo && shown_mm < near_hi) res.alarm_zone = ura_pkg::ZONE_NEAR;
    else if (shown_mm > far_lo && shown_mm < far_hi) res.alarm_zone = ura_pkg::ZONE_FAR;
    else res.alarm_zone = ura_pkg::ZONE_NONE;
    return res;
  endfunction

  // One ping request. Optional idle cycles first, then valid is held until
  // the handshake completes. Valid is left high so back-to-back requests
  // never see a low/high pair in the same step.
  task automatic send_ping(input ura_pkg::ura_in_t req, input logic use_row,
                           input ura_pkg::ura_out_t row_exp);
    ura_pkg::ura_out_t predicted;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    predicted = predict_range(req);
    pending_results.push_back(use_row ? row_exp : predicted);
    pings_sent++;
  endtask

  // Stop requesting and wait for the block to finish everything in flight.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four bounds, preceded by a write to an unused index that the
  // block must ignore. Valid stays high across the whole burst of writes.
  task automatic write_bounds(input logic [ura_pkg::BOUND_W-1:0] nl,
                              input logic [ura_pkg::BOUND_W-1:0] nh,
                              input logic [ura_pkg::BOUND_W-1:0] fl,
                              input logic [ura_pkg::BOUND_W-1:0] fh);
    logic [ura_pkg::CFG_IDX_W-1:0] idx;
    logic [ura_pkg::BOUND_W-1:0]   val;
    for (int k = 0; k < 5; k++) begin
      case (k)
        0: begin
          idx = ura_pkg::CFG_IDX_W'($urandom_range((1 << ura_pkg::CFG_IDX_W) - 1,
                                                   int'(ura_pkg::CFG_FAR_HIGH) + 1));
          val = ura_pkg::BOUND_W'($urandom);
        end
        1: begin idx = ura_pkg::CFG_NEAR_LOW;  val = nl; end
        2: begin idx = ura_pkg::CFG_NEAR_HIGH; val = nh; end
        3: begin idx = ura_pkg::CFG_FAR_LOW;   val = fl; end
        default: begin idx = ura_pkg::CFG_FAR_HIGH; val = fh; end
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      do @(posedge clk); while (!cfg_ready);
      case (idx)
        ura_pkg::CFG_NEAR_LOW:  near_lo = val;
        ura_pkg::CFG_NEAR_HIGH: near_hi = val;
        ura_pkg::CFG_FAR_LOW:   far_lo  = val;
        ura_pkg::CFG_FAR_HIGH:  far_hi  = val;
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    bound_settings++;
  endtask

  // Receiver: random back-pressure per phase, and in-order checking of
  // every accepted result against the oldest expectation.
  always @(posedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: distance %0d oor %0b zone %0d",
                 $time, out_data.distance_mm, out_data.out_of_range, out_data.alarm_zone);
        fail_count++;
      end else begin
        due_result = pending_results.pop_front();
        results_checked++;
        if (out_data.distance_mm !== due_result.distance_mm) begin
          $display("%0t: distance_mm expected %0d actual %0d",
                   $time, due_result.distance_mm, out_data.distance_mm);
          fail_count++;
        end
        if (out_data.out_of_range !== due_result.out_of_range) begin
          $display("%0t: out_of_range expected %0b actual %0b",
                   $time, due_result.out_of_range, out_data.out_of_range);
          fail_count++;
        end
        if (out_data.alarm_zone !== due_result.alarm_zone) begin
          $display("%0t: alarm_zone expected %0d actual %0d",
                   $time, due_result.alarm_zone, out_data.alarm_zone);
          fail_count++;
        end
        if (out_data.out_of_range) oor_seen++;
        if (out_data.alarm_zone == ura_pkg::ZONE_NEAR) near_seen++;
        if (out_data.alarm_zone == ura_pkg::ZONE_FAR) far_seen++;
      end
    end
  end

  initial begin : stimulus
    ura_pkg::ura_in_t            req;
    ura_pkg::ura_out_t           row_exp;
    logic [ura_pkg::BOUND_W-1:0] nl, nh, fl, fh;
    int                          burst_left;
    int                          burst_ticks;
    int                          burst_temp;
    int                          ticks_i;
    int                          roll;

    // model state after reset
    ring_slot    = 0;
    stored_count = 0;
    window_total = '0;
    near_lo = ura_pkg::NEAR_LOW_RST;
    near_hi = ura_pkg::NEAR_HIGH_RST;
    far_lo  = ura_pkg::FAR_LOW_RST;
    far_hi  = ura_pkg::FAR_HIGH_RST;
    foreach (ring_mm[i]) ring_mm[i] = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed pings under reset bounds, no idling on either side.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      req.echo_ticks        = DIRECTED[r].ticks;
      req.temperature_c     = DIRECTED[r].temp;
      req.echo_timeout      = DIRECTED[r].timeout;
      row_exp.distance_mm   = DIRECTED[r].dist_mm;
      row_exp.out_of_range  = DIRECTED[r].oor;
      row_exp.alarm_zone    = DIRECTED[r].zone;
      send_ping(req, DIRECTED[r].chk, row_exp);
    end

    // Random phases: each with its own bounds and idling pattern.
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        drain();
        case (phase)
          1: begin nl = 12'd100; nh = 12'd900;  fl = 12'd50;  fh = 12'd1200; end // overlapping
          2: begin nl = 12'd600; nh = 12'd200;  fl = 12'd900; fh = 12'd400;  end // inverted
          3: begin nl = 12'd300; nh = 12'd301;  fl = '1;      fh = '0;       end // empty
          4: begin nl = '0;      nh = '0;       fl = '0;      fh = '0;       end
          5: begin nl = '0;      nh = '1;       fl = '0;      fh = '1;       end
          6: begin
            nl = ura_pkg::BOUND_W'($urandom_range(600));
            nh = nl + ura_pkg::BOUND_W'($urandom_range(400, 1));
            fl = ura_pkg::BOUND_W'($urandom_range(800));
            fh = fl + ura_pkg::BOUND_W'($urandom_range(600));
          end
          7: begin
            nl = ura_pkg::BOUND_W'($urandom);
            nh = ura_pkg::BOUND_W'($urandom);
            fl = ura_pkg::BOUND_W'($urandom);
            fh = ura_pkg::BOUND_W'($urandom);
          end
          default: begin
            nl = ura_pkg::NEAR_LOW_RST;
            nh = ura_pkg::NEAR_HIGH_RST;
            fl = ura_pkg::FAR_LOW_RST;
            fh = ura_pkg::FAR_HIGH_RST;
          end
        endcase
        write_bounds(nl, nh, fl, fh);
      end

      // none / sender idles / receiver stalls / both lightly
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase

      burst_left = 0;
      for (int n = 0; n < PINGS_PER_PHASE; n++) begin
        // in odd phases, hold off mid-phase until the block has delivered everything
        if (phase % 2 == 1 && n == PINGS_PER_PHASE / 2) begin
          in_valid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
        if (burst_left == 0 && $urandom_range(99) < 15) begin
          // noise: anything the fields allow
          req.echo_ticks    = ura_pkg::TICKS_W'($urandom);
          req.temperature_c = ura_pkg::TEMP_W'($urandom);
          req.echo_timeout  = 1'($urandom);
        end else begin
          // bursts of similar echoes so the window mean settles on a target
          if (burst_left == 0) begin
            roll = int'($urandom_range(99));
            if (roll < 70) burst_ticks = int'($urandom_range(6000));
            else if (roll < 88) burst_ticks = int'($urandom_range(30000));
            else burst_ticks = int'($urandom_range(65535));
            burst_temp = int'($urandom_range(65)) - 20;
            burst_left = int'($urandom_range(20, 10));
          end
          burst_left--;
          ticks_i = burst_ticks + int'($urandom_range(400)) - 200;
          if (ticks_i < 0) ticks_i = 0;
          if (ticks_i > 65535) ticks_i = 65535;
          req.echo_ticks    = ura_pkg::TICKS_W'(ticks_i);
          req.temperature_c = ura_pkg::TEMP_W'(burst_temp + int'($urandom_range(2)) - 1);
          req.echo_timeout  = ($urandom_range(99) < 5);
        end
        row_exp = '0;
        send_ping(req, 1'b0, row_exp);
      end
    end

    drain();

    $display("Checked %0d results from %0d pings over %0d bound settings",
             results_checked, pings_sent, bound_settings);
    $display("and four idling patterns; %0d out of range, %0d near zone, %0d far zone.",
             oor_seen, near_seen, far_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/ura_pkg.sv
sv/ura_serdiv.sv
sv/ultrasonic_range_averager_top.sv
test/tb_ultrasonic_range_averager_top.sv
